>>> rtl/core/umsc_pkg.sv
// ----------------------------------------------------------------------------
// umsc_pkg
// Shared types and constants for the mass-storage configuration descriptor
// parser: descriptor codes, class codes, status codes and the result record.
// ----------------------------------------------------------------------------
package umsc_pkg;

    // Default and width of the block size limit
    localparam int MAX_BLOCK_BYTES_DEF = 512;
    localparam int TOTAL_W             = 10;

    // Descriptor types
    localparam logic [7:0] DESC_CONFIG    = 8'h02;
    localparam logic [7:0] DESC_INTERFACE = 8'h04;
    localparam logic [7:0] DESC_ENDPOINT  = 8'h05;

    // Mass storage, SCSI transparent, bulk-only transport
    localparam logic [7:0] CLASS_MSC     = 8'h08;
    localparam logic [7:0] SUBCLASS_SCSI = 8'h06;
    localparam logic [7:0] PROTO_BOT     = 8'h50;

    // Endpoint attributes and address
    localparam logic [1:0] EP_XFER_BULK = 2'b10;
    localparam int         EP_DIR_BIT   = 7;

    // Minimum lengths
    localparam logic [7:0] MIN_DESC_LEN = 8'd2;
    localparam logic [7:0] MIN_IF_LEN   = 8'd9;
    localparam logic [7:0] MIN_EP_LEN   = 8'd7;
    localparam int         MIN_TOTAL    = 9;

    // Header byte offsets
    localparam int HDR_KIND_POS   = 1;
    localparam int HDR_CONFIG_POS = 5;

    // Offsets within a descriptor
    localparam logic [TOTAL_W-1:0] REL_KIND     = 10'd1;
    localparam logic [TOTAL_W-1:0] REL_IF_NUM   = 10'd2;
    localparam logic [TOTAL_W-1:0] REL_IF_CLASS = 10'd5;
    localparam logic [TOTAL_W-1:0] REL_IF_SUB   = 10'd6;
    localparam logic [TOTAL_W-1:0] REL_IF_PROTO = 10'd7;
    localparam logic [TOTAL_W-1:0] REL_EP_ADDR  = 10'd2;
    localparam logic [TOTAL_W-1:0] REL_EP_ATTR  = 10'd3;

    localparam logic [7:0] NO_INTERFACE = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_FORMAT = 2'd1,
        STATUS_NOT_FOUND  = 2'd2
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] config_value;
        logic [7:0] iface_number;
        logic [7:0] bulk_in_endpoint;
        logic [7:0] bulk_out_endpoint;
    } report_t;

endpackage

>>> rtl/core/umsc_desc_if.sv
// ----------------------------------------------------------------------------
// umsc_desc_if
// Descriptor byte channel: one byte of the block per request.
// ----------------------------------------------------------------------------
interface umsc_desc_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   data_byte;
    logic [umsc_pkg::TOTAL_W-1:0] total_length;
    logic                         last_byte;

    modport source (output valid, output data_byte, output total_length,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input total_length,
                    input last_byte, output ready);
endinterface

>>> rtl/core/umsc_report_if.sv
// ----------------------------------------------------------------------------
// umsc_report_if
// Result channel: one parse report per descriptor block.
// ----------------------------------------------------------------------------
interface umsc_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] config_value;
    logic [7:0] iface_number;
    logic [7:0] bulk_in_endpoint;
    logic [7:0] bulk_out_endpoint;

    modport source (output valid, output status, output config_value,
                    output iface_number, output bulk_in_endpoint,
                    output bulk_out_endpoint, input ready);
    modport sink   (input valid, input status, input config_value,
                    input iface_number, input bulk_in_endpoint,
                    input bulk_out_endpoint, output ready);
endinterface

>>> rtl/core/usb_msc_config_descriptor_parser.sv
// ----------------------------------------------------------------------------
// usb_msc_config_descriptor_parser
// Walks a USB configuration descriptor block byte by byte and reports the
// mass-storage (SCSI, bulk-only) interface and its bulk endpoints.
// ----------------------------------------------------------------------------
// Usage:
//  - desc carries one descriptor byte per request, with the block's total
//    length and a last flag. Bytes go in block order.
//  - report carries one request per block, issued after the byte flagged
//    last: status (ok / bad format / not found), configuration value,
//    interface number and the bulk IN and OUT endpoint addresses.
//  - Throughput: one byte per cycle while the output register is free. Each
//    byte passes through compare and capture logic straight into the walk
//    state, so the walk state is updated as each byte is taken.
//  - The report is valid the cycle after the last byte is taken.
//  - The report sits in a single output register. While it waits, desc.ready
//    stays high only if report.ready is high, so one held report stalls the
//    byte stream but a report taken in the same cycle does not.
//  - Reset clears the walk state and empties the output register. After each
//    last byte the walk state returns to its reset values for the next block.
//  - Totals above MAX_BLOCK_BYTES are clamped; bytes past the total are not
//    walked.
// ----------------------------------------------------------------------------
module usb_msc_config_descriptor_parser #(
    parameter int MAX_BLOCK_BYTES = umsc_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    umsc_desc_if.sink     desc,
    umsc_report_if.source report
);

    logic              slot_free;
    logic              res_fire;
    umsc_pkg::report_t res;

    // Byte walk and report formation
    umsc_walker #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (desc),
        .slot_free (slot_free),
        .res_fire  (res_fire),
        .res       (res)
    );

    // Report holding register
    umsc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_fire  (res_fire),
        .res       (res),
        .slot_free (slot_free),
        .report    (report)
    );

endmodule

>>> rtl/core/umsc_walker.sv
// ----------------------------------------------------------------------------
// umsc_walker
// Per-byte descriptor walk: holds the walk state, updates it on every
// accepted byte and forms the report on the last byte of a block.
// ----------------------------------------------------------------------------
module umsc_walker #(
    parameter int MAX_BLOCK_BYTES = umsc_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    umsc_desc_if.sink           desc,
    input  logic                slot_free,
    output logic                res_fire,
    output umsc_pkg::report_t   res
);

    localparam int TW = umsc_pkg::TOTAL_W;
    localparam int OW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CW = ((OW > TW) ? OW : TW) + 1;

    localparam logic [OW-1:0] OFFSET_MAX = OW'(MAX_BLOCK_BYTES);
    localparam logic [CW-1:0] LIMIT      = CW'(MAX_BLOCK_BYTES);

    logic          accept;

    logic [OW-1:0] offset_reg,    offset_next;
    logic [TW-1:0] start_reg,     start_next;
    logic [7:0]    length_reg,    length_next;
    logic [7:0]    kind_reg,      kind_next;
    logic          stopped_reg,   stopped_next;
    logic [7:0]    hdr_kind_reg,  hdr_kind_next;
    logic [7:0]    hdr_cfg_reg,   hdr_cfg_next;
    logic          match_reg,     match_next;
    logic [7:0]    cap_reg [3];
    logic [7:0]    found_if_reg,  found_if_next;
    logic [7:0]    found_in_reg,  found_in_next;
    logic [7:0]    found_out_reg, found_out_next;

    logic [CW-1:0] total_ext, total_eff, pos_ext, start_ext;
    logic [TW-1:0] rel;
    logic [7:0]    kind_eff;
    logic          walk_en, at_start, start_bad;
    logic          in_if, in_ep;
    logic          cap0_we, cap1_we, cap2_we;
    logic          bad, missing;

    assign accept     = desc.valid && slot_free;
    assign desc.ready = slot_free;

    assign total_ext = CW'(desc.total_length);
    assign total_eff = (total_ext > LIMIT) ? LIMIT : total_ext;
    assign pos_ext   = CW'(offset_reg);
    assign start_ext = CW'(start_reg);

    assign walk_en   = !stopped_reg && (pos_ext < total_eff) && (pos_ext >= start_ext);
    assign at_start  = (pos_ext == start_ext);
    assign start_bad = (pos_ext + CW'(2) > total_eff) ||
                       (desc.data_byte < umsc_pkg::MIN_DESC_LEN) ||
                       (start_ext + CW'(desc.data_byte) > total_eff);

    // Position is below the total (at most 10 bits) whenever the walk is live
    assign rel      = TW'(pos_ext - start_ext);
    assign kind_eff = (rel == umsc_pkg::REL_KIND) ? desc.data_byte : kind_reg;
    assign in_if    = (kind_eff == umsc_pkg::DESC_INTERFACE) &&
                      (length_reg >= umsc_pkg::MIN_IF_LEN);
    assign in_ep    = (kind_eff == umsc_pkg::DESC_ENDPOINT) && match_reg &&
                      (length_reg >= umsc_pkg::MIN_EP_LEN);

    assign cap0_we = walk_en && !at_start &&
                     ((in_if && rel == umsc_pkg::REL_IF_NUM) ||
                      (!in_if && in_ep && rel == umsc_pkg::REL_EP_ADDR));
    assign cap1_we = walk_en && !at_start && in_if && rel == umsc_pkg::REL_IF_CLASS;
    assign cap2_we = walk_en && !at_start && in_if && rel == umsc_pkg::REL_IF_SUB;

    always_comb
    begin
        offset_next    = offset_reg;
        start_next     = start_reg;
        length_next    = length_reg;
        kind_next      = kind_reg;
        stopped_next   = stopped_reg;
        hdr_kind_next  = hdr_kind_reg;
        hdr_cfg_next   = hdr_cfg_reg;
        match_next     = match_reg;
        found_if_next  = found_if_reg;
        found_in_next  = found_in_reg;
        found_out_next = found_out_reg;

        if (pos_ext == CW'(umsc_pkg::HDR_KIND_POS))
        begin
            hdr_kind_next = desc.data_byte;
        end
        if (pos_ext == CW'(umsc_pkg::HDR_CONFIG_POS))
        begin
            hdr_cfg_next = desc.data_byte;
        end

        if (walk_en)
        begin
            if (at_start)
            begin
                if (start_bad)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    length_next = desc.data_byte;
                end
            end
            else
            begin
                kind_next = kind_eff;
                if (in_if)
                begin
                    if (rel == umsc_pkg::REL_IF_PROTO)
                    begin
                        match_next = (cap_reg[1] == umsc_pkg::CLASS_MSC) &&
                                     (cap_reg[2] == umsc_pkg::SUBCLASS_SCSI) &&
                                     (desc.data_byte == umsc_pkg::PROTO_BOT);
                        if (match_next)
                        begin
                            found_if_next = cap_reg[0];
                        end
                    end
                end
                else if (in_ep && rel == umsc_pkg::REL_EP_ATTR &&
                         desc.data_byte[1:0] == umsc_pkg::EP_XFER_BULK)
                begin
                    if (cap_reg[0][umsc_pkg::EP_DIR_BIT])
                    begin
                        found_in_next = cap_reg[0];
                    end
                    else
                    begin
                        found_out_next = cap_reg[0];
                    end
                end
                if ((TW + 1)'(rel) + (TW + 1)'(1) == (TW + 1)'(length_reg))
                begin
                    start_next = start_reg + TW'(length_reg);
                end
            end
        end

        if (offset_reg < OFFSET_MAX)
        begin
            offset_next = offset_reg + OW'(1);
        end
    end

    // Report from the state as it stands after this byte
    assign bad     = (total_eff < CW'(umsc_pkg::MIN_TOTAL)) ||
                     (hdr_kind_next != umsc_pkg::DESC_CONFIG);
    assign missing = (found_if_next == umsc_pkg::NO_INTERFACE) ||
                     (found_in_next == 8'd0) || (found_out_next == 8'd0);

    always_comb
    begin
        if (bad)
        begin
            res.status            = umsc_pkg::STATUS_BAD_FORMAT;
            res.config_value      = 8'd0;
            res.iface_number      = 8'd0;
            res.bulk_in_endpoint  = 8'd0;
            res.bulk_out_endpoint = 8'd0;
        end
        else
        begin
            res.status            = missing ? umsc_pkg::STATUS_NOT_FOUND
                                            : umsc_pkg::STATUS_OK;
            res.config_value      = hdr_cfg_next;
            res.iface_number      = found_if_next;
            res.bulk_in_endpoint  = found_in_next;
            res.bulk_out_endpoint = found_out_next;
        end
    end

    assign res_fire = accept && desc.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            start_reg     <= '0;
            length_reg    <= '0;
            kind_reg      <= '0;
            stopped_reg   <= 1'b0;
            hdr_kind_reg  <= '0;
            hdr_cfg_reg   <= '0;
            match_reg     <= 1'b0;
            found_if_reg  <= umsc_pkg::NO_INTERFACE;
            found_in_reg  <= '0;
            found_out_reg <= '0;
        end
        else if (accept)
        begin
            if (desc.last_byte)
            begin
                offset_reg    <= '0;
                start_reg     <= '0;
                length_reg    <= '0;
                kind_reg      <= '0;
                stopped_reg   <= 1'b0;
                hdr_kind_reg  <= '0;
                hdr_cfg_reg   <= '0;
                match_reg     <= 1'b0;
                found_if_reg  <= umsc_pkg::NO_INTERFACE;
                found_in_reg  <= '0;
                found_out_reg <= '0;
            end
            else
            begin
                offset_reg    <= offset_next;
                start_reg     <= start_next;
                length_reg    <= length_next;
                kind_reg      <= kind_next;
                stopped_reg   <= stopped_next;
                hdr_kind_reg  <= hdr_kind_next;
                hdr_cfg_reg   <= hdr_cfg_next;
                match_reg     <= match_next;
                found_if_reg  <= found_if_next;
                found_in_reg  <= found_in_next;
                found_out_reg <= found_out_next;
            end
        end
    end

    // Field captures: always written before read within a descriptor
    always_ff @(posedge clk)
    begin
        if (accept && cap0_we)
        begin
            cap_reg[0] <= desc.data_byte;
        end
        if (accept && cap1_we)
        begin
            cap_reg[1] <= desc.data_byte;
        end
        if (accept && cap2_we)
        begin
            cap_reg[2] <= desc.data_byte;
        end
    end

endmodule

>>> rtl/core/umsc_out_reg.sv
// ----------------------------------------------------------------------------
// umsc_out_reg
// Result register: holds one report until the receiver takes it.
// ----------------------------------------------------------------------------
module umsc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_fire,
    input  umsc_pkg::report_t res,
    output logic              slot_free,
    umsc_report_if.source     report
);

    logic              valid_reg;
    umsc_pkg::report_t data_reg;

    // Free when empty or being emptied this cycle
    assign slot_free = !valid_reg || report.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            data_reg <= res;
        end
    end

    assign report.valid             = valid_reg;
    assign report.status            = data_reg.status;
    assign report.config_value      = data_reg.config_value;
    assign report.iface_number      = data_reg.iface_number;
    assign report.bulk_in_endpoint  = data_reg.bulk_in_endpoint;
    assign report.bulk_out_endpoint = data_reg.bulk_out_endpoint;

endmodule
